// File: sv/smd_pkg.sv
// Shared types and constants for the SHA-1 message digest block.
`default_nettype none
package smd_pkg;

	localparam int WordW    = 32;
	localparam int HashN    = 5;
	localparam int BlockW   = 512;
	localparam int IndexW   = 3;
	localparam int RoundW   = 7;
	localparam int FillW    = 6;

	localparam logic [WordW-1:0] H_INIT [HashN] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam logic [WordW-1:0] K_CHOOSE = 32'h5A827999;
	localparam logic [WordW-1:0] K_PARITY1 = 32'h6ED9EBA1;
	localparam logic [WordW-1:0] K_MAJORITY = 32'h8F1BBCDC;
	localparam logic [WordW-1:0] K_PARITY3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [IndexW-1:0] LAST_INDEX = 3'd4;
	localparam logic [RoundW-1:0] LAST_ROUND = 7'd79;

	typedef enum logic [1:0] {
		PH_CHOOSE,
		PH_PARITY1,
		PH_MAJORITY,
		PH_PARITY3
	} phase_t;

	typedef enum logic [1:0] {
		SRC_DATA,
		SRC_PAD,
		SRC_ZERO,
		SRC_LEN
	} byte_src_t;

	typedef struct packed {
		logic              shift_en;
		byte_src_t         byte_src;
		logic [2:0]        len_sel;
		logic              count_en;
		logic              round_load;
		logic              round_step;
		phase_t            phase;
		logic              hash_add;
		logic              hash_init;
		logic              out_load;
		logic [IndexW-1:0] out_index;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

endpackage
`default_nettype wire

// File: sv/smd_datapath.sv
// Datapath: block shift register and schedule, round unit, hash words, output register.
`default_nettype none
module smd_datapath (
	input  wire                    clk,
	input  wire                    arst_n,
	input  smd_pkg::cmd_t          cmd,
	output smd_pkg::status_t       status,
	input  wire  [7:0]             data_byte,
	output logic                   m_tvalid,
	input  wire                    m_tready,
	output logic [31:0]            m_tdata,   // digest_word
	output logic [2:0]             m_tuser,   // word_index
	output logic                   m_tlast    // last_word
);
	import smd_pkg::*;

	logic [BlockW-1:0] blk_q;
	logic [63:0]       bits_q;
	logic [WordW-1:0]  hash_q [HashN];
	logic [WordW-1:0]  a_q, b_q, c_q, d_q, e_q;

	logic              out_valid_q;
	logic [WordW-1:0]  out_word_q;
	logic [IndexW-1:0] out_index_q;

	logic [7:0]        in_byte;
	logic [7:0]        len_byte;
	logic [WordW-1:0]  w0, w2, w8, w13, w_mix, w_new;
	logic [WordW-1:0]  f, k, t;

	assign len_byte = 8'(bits_q >> {3'(~cmd.len_sel), 3'b000});

	always_comb begin
		case (cmd.byte_src)
			SRC_DATA: in_byte = data_byte;
			SRC_PAD:  in_byte = PAD_BYTE;
			SRC_LEN:  in_byte = len_byte;
			default:  in_byte = 8'h00;
		endcase
	end

	// The block register holds a sliding window W[t..t+15], word 0 in the top bits.
	assign w0    = blk_q[511:480];
	assign w2    = blk_q[447:416];
	assign w8    = blk_q[255:224];
	assign w13   = blk_q[95:64];
	assign w_mix = w13 ^ w8 ^ w2 ^ w0;
	assign w_new = {w_mix[30:0], w_mix[31]};

	always_comb begin
		case (cmd.phase)
			PH_CHOOSE: begin
				f = (b_q & c_q) | (~b_q & d_q);
				k = K_CHOOSE;
			end
			PH_PARITY1: begin
				f = b_q ^ c_q ^ d_q;
				k = K_PARITY1;
			end
			PH_MAJORITY: begin
				f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
				k = K_MAJORITY;
			end
			default: begin
				f = b_q ^ c_q ^ d_q;
				k = K_PARITY3;
			end
		endcase
	end

	assign t = {a_q[26:0], a_q[31:27]} + f + e_q + w0 + k;

	always_ff @(posedge clk) begin
		if (cmd.shift_en) begin
			blk_q <= {blk_q[BlockW-9:0], in_byte};
		end else if (cmd.round_step) begin
			blk_q <= {blk_q[BlockW-WordW-1:0], w_new};
		end
		if (cmd.round_load) begin
			a_q <= hash_q[0];
			b_q <= hash_q[1];
			c_q <= hash_q[2];
			d_q <= hash_q[3];
			e_q <= hash_q[4];
		end else if (cmd.round_step) begin
			a_q <= t;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
		if (cmd.out_load) begin
			out_word_q  <= hash_q[cmd.out_index];
			out_index_q <= cmd.out_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q      <= '0;
			hash_q      <= H_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.hash_init) begin
				bits_q <= '0;
				hash_q <= H_INIT;
			end else begin
				if (cmd.count_en) begin
					bits_q <= bits_q + 64'd8;
				end
				if (cmd.hash_add) begin
					hash_q[0] <= hash_q[0] + a_q;
					hash_q[1] <= hash_q[1] + b_q;
					hash_q[2] <= hash_q[2] + c_q;
					hash_q[3] <= hash_q[3] + d_q;
					hash_q[4] <= hash_q[4] + e_q;
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_word_q;
	assign m_tuser  = out_index_q;
	assign m_tlast  = (out_index_q == LAST_INDEX);

endmodule
`default_nettype wire

// File: sv/smd_ctrl.sv
// Controller: sequences byte intake, padding, the 80 rounds and digest output.
`default_nettype none
module smd_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               s_tvalid,
	output logic              s_tready,
	input  wire               func,
	input  smd_pkg::status_t  status,
	output smd_pkg::cmd_t     cmd
);
	import smd_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_UPDATE,
		ST_EMIT
	} state_t;

	state_t            state_q;
	logic [FillW-1:0]  fill_q;
	logic [RoundW-1:0] round_q;
	logic [IndexW-1:0] idx_q;
	logic              first_q;
	logic              lenok_q;
	logic              pad_q;
	logic              final_q;
	logic              lenok_d;
	logic              block_full;

	assign block_full = (fill_q == '1);

	// The length goes in this block only if the pad marker leaves room for it.
	assign lenok_d = first_q ? (fill_q < 6'd56) : lenok_q;

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		cmd.len_sel = fill_q[2:0];
		if (round_q < 7'd20) begin
			cmd.phase = PH_CHOOSE;
		end else if (round_q < 7'd40) begin
			cmd.phase = PH_PARITY1;
		end else if (round_q < 7'd60) begin
			cmd.phase = PH_MAJORITY;
		end else begin
			cmd.phase = PH_PARITY3;
		end
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && !func) begin
					cmd.shift_en   = 1'b1;
					cmd.byte_src   = SRC_DATA;
					cmd.count_en   = 1'b1;
					cmd.round_load = block_full;
				end
			end
			ST_PAD: begin
				cmd.shift_en = 1'b1;
				if (first_q) begin
					cmd.byte_src = SRC_PAD;
				end else if (lenok_q && fill_q >= 6'd56) begin
					cmd.byte_src = SRC_LEN;
				end else begin
					cmd.byte_src = SRC_ZERO;
				end
				cmd.round_load = block_full;
			end
			ST_ROUND: begin
				cmd.round_step = 1'b1;
			end
			ST_UPDATE: begin
				cmd.hash_add = 1'b1;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.out_load  = 1'b1;
					cmd.out_index = idx_q;
					cmd.hash_init = (idx_q == LAST_INDEX);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			round_q <= '0;
			idx_q   <= '0;
			first_q <= 1'b0;
			lenok_q <= 1'b0;
			pad_q   <= 1'b0;
			final_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						if (func) begin
							state_q <= ST_PAD;
							first_q <= 1'b1;
							pad_q   <= 1'b1;
						end else begin
							fill_q <= fill_q + 1'b1;
							if (block_full) begin
								state_q <= ST_ROUND;
								round_q <= '0;
							end
						end
					end
				end
				ST_PAD: begin
					first_q <= 1'b0;
					// A block that had no room for the length hands it to the next block.
					lenok_q <= lenok_d || block_full;
					fill_q  <= fill_q + 1'b1;
					if (block_full) begin
						state_q <= ST_ROUND;
						round_q <= '0;
						final_q <= lenok_d;
					end
				end
				ST_ROUND: begin
					round_q <= round_q + 1'b1;
					if (round_q == LAST_ROUND) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (final_q) begin
						state_q <= ST_EMIT;
						idx_q   <= '0;
					end else if (pad_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (status.out_free) begin
						if (idx_q == LAST_INDEX) begin
							state_q <= ST_IDLE;
							fill_q  <= '0;
							pad_q   <= 1'b0;
							final_q <= 1'b0;
							lenok_q <= 1'b0;
							idx_q   <= '0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: sv/sha1_message_digest_top.sv
// Top level of the SHA-1 message digest block.
// An absorb word (tuser 0) shifts its byte into the block. Each 64th byte starts a
// compression of 80 rounds, one round per cycle through a single round adder, then
// adds into the hash words; the input is held off through the rounds and that add.
// A finish word (tuser 1) feeds the padding and length one byte per cycle up to the
// end of the block, runs one or two compressions, then loads the five digest words
// into the output register, one per cycle as the sink takes them. The input is taken
// again once the fifth word sits in the output register.
`default_nettype none
module sha1_message_digest_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // data_byte
	input  wire         s_tuser,   // func
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,   // digest_word
	output logic [2:0]  m_tuser,   // word_index
	output logic        m_tlast    // last_word
);
	import smd_pkg::*;

	cmd_t    cmd;
	status_t status;

	smd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.func     (s_tuser),
		.status   (status),
		.cmd      (cmd)
	);

	smd_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.data_byte (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
`default_nettype wire
